// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// CC_ASSERT checks a property on every rising clock edge outside reset.
// CC_NEVER checks that an expression is never true outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");
`define CC_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition seen");
`else
`define CC_ASSERT(lbl, clk, rst_n, prop)
`define CC_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== rtl/chacha_pkg.sv =====
`default_nettype none

package chacha_pkg;

	// Payload and datapath widths.
	localparam int DATA_W      = 8;
	localparam int WORD_W      = 32;
	localparam int NUM_WORDS   = 16;
	localparam int LANES       = 4;
	localparam int BLOCK_BYTES = 64;
	localparam int POS_W       = 7;

	// Number of double rounds per block.
	localparam int DOUBLE_ROUNDS = 10;
	localparam int ROUND_W       = $clog2(DOUBLE_ROUNDS);

	// Register port geometry: 64-bit registers on 8-byte boundaries.
	localparam int REG_W  = 64;
	localparam int ADDR_W = 6;

	typedef logic [WORD_W-1:0] word_t;

	// The four "expand 32-byte k" constant words.
	localparam word_t SIGMA [LANES] = '{
		32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
	};

	// Register indexes; index 7 is unmapped.
	typedef enum logic [2:0] {
		REG_KEY0    = 3'd0,
		REG_KEY1    = 3'd1,
		REG_KEY2    = 3'd2,
		REG_KEY3    = 3'd3,
		REG_NONCE01 = 3'd4,
		REG_NONCE2  = 3'd5,
		REG_COUNTER = 3'd6
	} reg_idx_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/chacha_in_if.sv =====
`default_nettype none

// Request channel carrying one byte and its end-of-call mark.
interface chacha_in_if;
	logic                           valid;
	logic                           ready;
	logic [chacha_pkg::DATA_W-1:0]  data_in;
	logic                           last_of_call;

	modport source (output valid, output data_in, output last_of_call, input ready);
	modport sink (input valid, input data_in, input last_of_call, output ready);
endinterface

`default_nettype wire

// ===== rtl/chacha_out_if.sv =====
`default_nettype none

// Result channel carrying one processed byte.
interface chacha_out_if;
	logic                           valid;
	logic                           ready;
	logic [chacha_pkg::DATA_W-1:0]  data_out;

	modport source (output valid, output data_out, input ready);
	modport sink (input valid, input data_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/chacha20_stream_cipher.sv =====
// A byte inside a ready keystream block is accepted in the idle state; its result is
// registered in the emit state, which waits while an earlier result is still held, and
// no new byte is taken before then. A byte needing a new block first passes the round
// states: one four-lane quarter-round step unit does one add/xor/rotate step per cycle.
// Reset (arst_n low, asynchronous) clears the configuration and control registers and
// marks a new block as needed; no clearing pass is required after reset.
`default_nettype none
`include "assert_macros.svh"

module chacha20_stream_cipher (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [chacha_pkg::ADDR_W-1:0]     paddr,
	input  logic [chacha_pkg::REG_W-1:0]      pwdata,
	output logic [chacha_pkg::REG_W-1:0]      prdata,
	output logic                              pready,
	chacha_in_if.sink                         item,
	chacha_out_if.source                      result
);

	localparam int NW = chacha_pkg::NUM_WORDS;
	localparam int NL = chacha_pkg::LANES;

	chacha_pkg::state_t   state_q, state_d;
	chacha_pkg::reg_idx_t reg_idx;

	// Configuration registers.
	logic [chacha_pkg::REG_W-1:0]    key_q [NL];
	logic [chacha_pkg::REG_W-1:0]    nonce01_q;
	chacha_pkg::word_t               nonce2_q;
	chacha_pkg::word_t               ctr_init_q;

	// Stream state.
	chacha_pkg::word_t               ctr_q;
	logic [chacha_pkg::POS_W-1:0]    pos_q;
	logic [1:0]                      step_q;
	logic                            diag_q;
	logic [chacha_pkg::ROUND_W-1:0]  rnd_q;

	// Working block: round state while rounds run, keystream afterwards.
	chacha_pkg::word_t               work_q [NW];
	chacha_pkg::word_t               init_w [NW];
	chacha_pkg::word_t               round_nxt [NW];
	chacha_pkg::word_t               perm_nxt [NW];
	chacha_pkg::word_t               lane_sum [NL];
	chacha_pkg::word_t               lane_mix [NL];
	chacha_pkg::word_t               lane_x [NL];

	logic [chacha_pkg::DATA_W-1:0]   data_q;
	logic                            last_q;
	logic [chacha_pkg::DATA_W-1:0]   out_data_q;
	logic                            out_valid_q;
	chacha_pkg::word_t               ks_word;
	logic [chacha_pkg::DATA_W-1:0]   ks_byte;

	logic cfg_wr;
	logic accept;
	logic emit;
	logic last_step;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = chacha_pkg::reg_idx_t'(paddr[chacha_pkg::ADDR_W-1:3]);
	assign accept  = item.valid && item.ready;

	assign result.valid    = out_valid_q;
	assign result.data_out = out_data_q;

	// Register read mux.
	always_comb begin
		case (reg_idx)
			chacha_pkg::REG_KEY0:    prdata = key_q[0];
			chacha_pkg::REG_KEY1:    prdata = key_q[1];
			chacha_pkg::REG_KEY2:    prdata = key_q[2];
			chacha_pkg::REG_KEY3:    prdata = key_q[3];
			chacha_pkg::REG_NONCE01: prdata = nonce01_q;
			chacha_pkg::REG_NONCE2:  prdata = {32'b0, nonce2_q};
			chacha_pkg::REG_COUNTER: prdata = {32'b0, ctr_init_q};
			default:                 prdata = '0;
		endcase
	end

	// Initial block state from constants, key, counter and nonce.
	always_comb begin
		for (int i = 0; i < NL; i++) begin
			init_w[i]         = chacha_pkg::SIGMA[i];
			init_w[NL + 2*i]     = key_q[i][31:0];
			init_w[NL + 2*i + 1] = key_q[i][63:32];
		end
		init_w[12] = ctr_q;
		init_w[13] = nonce01_q[31:0];
		init_w[14] = nonce01_q[63:32];
		init_w[15] = nonce2_q;
	end

	// Shared step unit: each lane does one add, xor and rotate of a quarter round.
	// Even steps update rows a and d, odd steps update rows c and b.
	always_comb begin
		for (int l = 0; l < NL; l++) begin
			if (!step_q[0]) begin
				lane_sum[l] = work_q[l] + work_q[NL + l];
				lane_x[l]   = work_q[3*NL + l] ^ lane_sum[l];
			end else begin
				lane_sum[l] = work_q[2*NL + l] + work_q[3*NL + l];
				lane_x[l]   = work_q[NL + l] ^ lane_sum[l];
			end
			case (step_q)
				2'd0:    lane_mix[l] = {lane_x[l][15:0], lane_x[l][31:16]};
				2'd1:    lane_mix[l] = {lane_x[l][19:0], lane_x[l][31:20]};
				2'd2:    lane_mix[l] = {lane_x[l][23:0], lane_x[l][31:24]};
				default: lane_mix[l] = {lane_x[l][24:0], lane_x[l][31:25]};
			endcase
		end
	end

	// Write back, then on the last step of a half round rotate rows b, c and d so
	// that the next half round again works on plain columns.
	always_comb begin
		round_nxt = work_q;
		for (int l = 0; l < NL; l++) begin
			if (!step_q[0]) begin
				round_nxt[l]          = lane_sum[l];
				round_nxt[3*NL + l]   = lane_mix[l];
			end else begin
				round_nxt[2*NL + l]   = lane_sum[l];
				round_nxt[NL + l]     = lane_mix[l];
			end
		end
		perm_nxt = round_nxt;
		if (step_q == 2'd3) begin
			for (int l = 0; l < NL; l++) begin
				if (!diag_q) begin
					perm_nxt[NL + l]   = round_nxt[NL + ((l + 1) % NL)];
					perm_nxt[2*NL + l] = round_nxt[2*NL + ((l + 2) % NL)];
					perm_nxt[3*NL + l] = round_nxt[3*NL + ((l + 3) % NL)];
				end else begin
					perm_nxt[NL + l]   = round_nxt[NL + ((l + 3) % NL)];
					perm_nxt[2*NL + l] = round_nxt[2*NL + ((l + 2) % NL)];
					perm_nxt[3*NL + l] = round_nxt[3*NL + ((l + 1) % NL)];
				end
			end
		end
	end

	// Keystream byte at the current position, little-endian within each word.
	assign ks_word = work_q[pos_q[5:2]];
	assign ks_byte = ks_word[{pos_q[1:0], 3'b000} +: chacha_pkg::DATA_W];

	assign last_step = (step_q == 2'd3) && diag_q &&
		(rnd_q == chacha_pkg::ROUND_W'(chacha_pkg::DOUBLE_ROUNDS - 1));

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chacha_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state and handshake.
	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		emit       = 1'b0;
		case (state_q)
			chacha_pkg::ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					state_d = pos_q[6] ? chacha_pkg::ST_ROUND : chacha_pkg::ST_EMIT;
				end
			end
			chacha_pkg::ST_ROUND: begin
				if (last_step) begin
					state_d = chacha_pkg::ST_ADD;
				end
			end
			chacha_pkg::ST_ADD: begin
				state_d = chacha_pkg::ST_EMIT;
			end
			chacha_pkg::ST_EMIT: begin
				if (!out_valid_q || result.ready) begin
					emit    = 1'b1;
					state_d = chacha_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = chacha_pkg::ST_IDLE;
			end
		endcase
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= item.data_in;
			last_q <= item.last_of_call;
		end
		if (accept && pos_q[6]) begin
			work_q <= init_w;
		end else if (state_q == chacha_pkg::ST_ROUND) begin
			work_q <= perm_nxt;
		end else if (state_q == chacha_pkg::ST_ADD) begin
			for (int i = 0; i < NW; i++) begin
				work_q[i] <= work_q[i] + init_w[i];
			end
		end
		if (emit) begin
			out_data_q <= data_q ^ ks_byte;
		end
	end

	// Control and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NL; i++) begin
				key_q[i] <= '0;
			end
			nonce01_q   <= '0;
			nonce2_q    <= '0;
			ctr_init_q  <= '0;
			ctr_q       <= '0;
			pos_q       <= chacha_pkg::POS_W'(chacha_pkg::BLOCK_BYTES);
			step_q      <= '0;
			diag_q      <= 1'b0;
			rnd_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Round counters start with every new block.
			if (accept && pos_q[6]) begin
				step_q <= '0;
				diag_q <= 1'b0;
				rnd_q  <= '0;
			end else if (state_q == chacha_pkg::ST_ROUND) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					diag_q <= !diag_q;
					if (diag_q && !last_step) begin
						rnd_q <= rnd_q + chacha_pkg::ROUND_W'(1);
					end
				end
			end

			// Block finished: counter advances, stream restarts at byte zero.
			if (state_q == chacha_pkg::ST_ADD) begin
				ctr_q <= ctr_q + 32'd1;
				pos_q <= '0;
			end

			if (emit) begin
				pos_q <= last_q ? chacha_pkg::POS_W'(chacha_pkg::BLOCK_BYTES)
				                : pos_q + chacha_pkg::POS_W'(1);
			end

			// Output register.
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			// Register writes.
			if (cfg_wr) begin
				case (reg_idx)
					chacha_pkg::REG_KEY0:    key_q[0]  <= pwdata;
					chacha_pkg::REG_KEY1:    key_q[1]  <= pwdata;
					chacha_pkg::REG_KEY2:    key_q[2]  <= pwdata;
					chacha_pkg::REG_KEY3:    key_q[3]  <= pwdata;
					chacha_pkg::REG_NONCE01: nonce01_q <= pwdata;
					chacha_pkg::REG_NONCE2:  nonce2_q  <= pwdata[31:0];
					chacha_pkg::REG_COUNTER: begin
						ctr_init_q <= pwdata[31:0];
						ctr_q      <= pwdata[31:0];
						pos_q      <= chacha_pkg::POS_W'(chacha_pkg::BLOCK_BYTES);
					end
					default: begin
					end
				endcase
			end
		end
	end

	// A request that finds no keystream left starts the rounds.
	`CC_ASSERT(a_block_start, clk, arst_n, (accept && pos_q[6]) |=> (state_q == chacha_pkg::ST_ROUND))
	// Finishing a block rewinds pos_q (barring a counter write) and moves on to the result.
	`CC_ASSERT(a_add_rewinds, clk, arst_n, (state_q == chacha_pkg::ST_ADD) |=> (pos_q == '0 && state_q == chacha_pkg::ST_EMIT))
	// A new result only ever comes out of the emit state.
	`CC_ASSERT(a_result_src, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == chacha_pkg::ST_EMIT))
	// The double-round counter stays in range.
	`CC_NEVER(a_round_range, clk, arst_n, rnd_q >= chacha_pkg::ROUND_W'(chacha_pkg::DOUBLE_ROUNDS))
	// The byte position never passes the block size.
	`CC_NEVER(a_pos_range, clk, arst_n, pos_q[6] && (pos_q[5:0] != 6'd0))

endmodule

`default_nettype wire
